[design/linked_block_file_store_unit_defines.svh]
// ----------------------------------------------------------------------------
// linked_block_file_store_unit_defines
// Assertion macros shared by the checker files of the block.
// ----------------------------------------------------------------------------
`ifndef LINKED_BLOCK_FILE_STORE_UNIT_DEFINES_SVH
`define LINKED_BLOCK_FILE_STORE_UNIT_DEFINES_SVH

// check a consequence in the same cycle
`define LBFS_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lbfs check failed: same-cycle rule");

// check a consequence in the next cycle
`define LBFS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lbfs check failed: next-cycle rule");

`endif

[design/lbfs_pkg.sv]
// ----------------------------------------------------------------------------
// lbfs_pkg
// Types, sizes and codes of the linked block file store.
// ----------------------------------------------------------------------------
package lbfs_pkg;

	localparam int NUM_FILES   = 16;
	localparam int DISK_BLOCKS = 64;
	localparam int BLOCK_BYTES = 512;

	localparam int FUNC_W = 2;
	localparam int FILE_W = 4;
	localparam int POS_W  = 15;
	localparam int SIZE_W = 16;
	localparam int DATA_W = 8;
	localparam int STAT_W = 3;

	localparam int BLIM_W    = 7;
	localparam int FLIM_W    = 5;
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 1;

	localparam int BLK_W   = $clog2(DISK_BLOCKS);
	localparam int OFF_W   = $clog2(BLOCK_BYTES);
	localparam int HOP_W   = POS_W - OFF_W;
	localparam int SCAN_W  = BLK_W + 1;
	localparam int BADDR_W = BLK_W + OFF_W;
	localparam int LINK_W  = 8;
	localparam int NEED_W  = SIZE_W - OFF_W + 2;

	localparam int ALLOC_BIAS = BLOCK_BYTES - 1 + (3 * BLOCK_BYTES) / 4;

	localparam logic [LINK_W-1:0] LINK_END = 8'hFE;

	localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_FILES  = 1'b1;

	localparam logic [FUNC_W-1:0] FN_ALLOC = 2'd0;
	localparam logic [FUNC_W-1:0] FN_READ  = 2'd1;
	localparam logic [FUNC_W-1:0] FN_WRITE = 2'd2;
	localparam logic [FUNC_W-1:0] FN_NONE  = 2'd3;

	localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
	localparam logic [STAT_W-1:0] ST_NO_FILE  = 3'd1;
	localparam logic [STAT_W-1:0] ST_NO_BLOCK = 3'd2;
	localparam logic [STAT_W-1:0] ST_PAST_END = 3'd3;
	localparam logic [STAT_W-1:0] ST_NOT_USED = 3'd4;

	typedef enum logic [1:0] {RD_ZERO, RD_FF, RD_MEM} rdsel_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [FILE_W-1:0] file_index;
		logic [POS_W-1:0]  position;
		logic [SIZE_W-1:0] alloc_size;
		logic [DATA_W-1:0] write_data;
	} in_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [FILE_W-1:0] new_file;
		logic [DATA_W-1:0] read_data;
	} out_t;

	typedef struct packed {
		logic              latch;
		logic              clr_step;
		logic              scan_rst;
		logic              scan_step;
		logic              cnt_step;
		logic              take;
		logic              file_commit;
		logic              link_wr;
		logic              rb_first;
		logic              rb_follow;
		logic              byte_wr;
		logic              res_load;
		logic [STAT_W-1:0] res_status;
		rdsel_t            res_rdsel;
		logic              res_newf;
	} cmd_t;

	typedef struct packed {
		logic              clear_done;
		logic [FUNC_W-1:0] func;
		logic              file_found;
		logic              file_ok;
		logic              scan_end;
		logic              scan_free;
		logic              enough;
		logic              first_take;
		logic              taken_all;
		logic              hops_done;
		logic              rb_free;
		logic              link_end;
	} sts_t;

endpackage

[design/lbfs_ram.sv]
// ----------------------------------------------------------------------------
// lbfs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lbfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[design/lbfs_ctrl.sv]
// ----------------------------------------------------------------------------
// lbfs_ctrl
// Command sequencer: clear pass, allocate, chain walk, extend, result.
// ----------------------------------------------------------------------------
module lbfs_ctrl
	import lbfs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_DISP, S_CNT, S_CHK, S_AFIND, S_ALINK, S_ANEXT,
		S_HOP, S_LWAIT, S_XFIND, S_XLINK, S_RWAIT, S_FIN
	} state_t;

	state_t            state_q, state_d;
	logic [STAT_W-1:0] code_q, code_d;
	rdsel_t            rdsel_q, rdsel_d;
	logic              newf_q, newf_d;
	logic              out_valid_q;
	logic              out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd        = '0;
		cmd.res_status = code_q;
		cmd.res_rdsel  = rdsel_q;
		cmd.res_newf   = newf_q;
		state_d    = state_q;
		code_d     = code_q;
		rdsel_d    = rdsel_q;
		newf_d     = newf_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clear_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_DISP;
				end
			end
			S_DISP: begin
				code_d  = ST_OK;
				rdsel_d = RD_ZERO;
				newf_d  = 1'b0;
				unique case (sts.func)
					FN_ALLOC: begin
						if (sts.file_found) begin
							state_d = S_CNT;
						end else begin
							code_d  = ST_NO_FILE;
							state_d = S_FIN;
						end
					end
					FN_READ, FN_WRITE: begin
						if (sts.file_ok) begin
							cmd.rb_first = 1'b1;
							state_d      = S_HOP;
						end else begin
							code_d  = ST_NOT_USED;
							rdsel_d = (sts.func == FN_READ) ? RD_FF : RD_ZERO;
							state_d = S_FIN;
						end
					end
					default: state_d = S_FIN;
				endcase
			end
			S_CNT: begin
				if (sts.scan_end) begin
					state_d = S_CHK;
				end else begin
					cmd.cnt_step = 1'b1;
				end
			end
			S_CHK: begin
				cmd.scan_rst = 1'b1;
				if (sts.enough) begin
					state_d = S_AFIND;
				end else begin
					code_d  = ST_NO_BLOCK;
					state_d = S_FIN;
				end
			end
			S_AFIND: begin
				if (sts.scan_free) begin
					cmd.take        = 1'b1;
					cmd.file_commit = sts.first_take;
					state_d         = sts.first_take ? S_ANEXT : S_ALINK;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_ALINK: begin
				cmd.link_wr = 1'b1;
				state_d     = S_ANEXT;
			end
			S_ANEXT: begin
				if (sts.taken_all) begin
					newf_d  = 1'b1;
					state_d = S_FIN;
				end else begin
					cmd.scan_step = 1'b1;
					state_d       = S_AFIND;
				end
			end
			S_HOP: begin
				if (sts.hops_done) begin
					if (sts.func == FN_READ) begin
						state_d = S_RWAIT;
					end else begin
						cmd.byte_wr = 1'b1;
						state_d     = S_FIN;
					end
				end else if (sts.rb_free) begin
					code_d  = ST_PAST_END;
					rdsel_d = (sts.func == FN_READ) ? RD_FF : RD_ZERO;
					state_d = S_FIN;
				end else begin
					state_d = S_LWAIT;
				end
			end
			S_LWAIT: begin
				if (!sts.link_end) begin
					cmd.rb_follow = 1'b1;
					state_d       = S_HOP;
				end else if (sts.func == FN_READ) begin
					code_d  = ST_PAST_END;
					rdsel_d = RD_FF;
					state_d = S_FIN;
				end else begin
					cmd.scan_rst = 1'b1;
					state_d      = S_XFIND;
				end
			end
			S_XFIND: begin
				if (sts.scan_end) begin
					code_d  = ST_NO_BLOCK;
					state_d = S_FIN;
				end else if (sts.scan_free) begin
					cmd.take = 1'b1;
					state_d  = S_XLINK;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_XLINK: begin
				cmd.link_wr = 1'b1;
				state_d     = S_HOP;
			end
			S_RWAIT: begin
				rdsel_d = RD_MEM;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (out_free) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			code_q      <= ST_OK;
			rdsel_q     <= RD_ZERO;
			newf_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
			rdsel_q <= rdsel_d;
			newf_q  <= newf_d;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[design/lbfs_dpath.sv]
// ----------------------------------------------------------------------------
// lbfs_dpath
// File table, free map, link and byte memories, scan and hop counters.
// ----------------------------------------------------------------------------
module lbfs_dpath
	import lbfs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  in_t                  in_data,
	output out_t                 out_data,
	input  cmd_t                 cmd,
	output sts_t                 sts
);

	logic [BLIM_W-1:0] blk_lim_q;
	logic [FLIM_W-1:0] file_lim_q;
	in_t               item_q;
	logic [NUM_FILES-1:0]  used_q;
	logic [BLK_W-1:0]  first_q [NUM_FILES];
	logic [SIZE_W-1:0] len_q [NUM_FILES];
	logic [DISK_BLOCKS-1:0] free_q;
	logic [BLK_W-1:0]  rb_q;
	logic [HOP_W-1:0]  hop_q;
	logic [SCAN_W-1:0] scan_q;
	logic [SCAN_W-1:0] avail_q;
	logic [NEED_W-1:0] taken_q;
	logic [BADDR_W-1:0] clr_q;
	logic [FILE_W-1:0] fnew_q;
	out_t              out_q;

	logic [FLIM_W-1:0] flim;
	logic [BLIM_W-1:0] blim;
	logic              ffound;
	logic [FILE_W-1:0] fidx;
	logic [HOP_W-1:0]  hops;
	logic [OFF_W-1:0]  off;
	logic [SIZE_W:0]   size_b;
	logic [NEED_W-1:0] need;
	logic              scan_free;

	logic               byte_we;
	logic [BADDR_W-1:0] byte_waddr;
	logic [DATA_W-1:0]  byte_wdata;
	logic [DATA_W-1:0]  byte_rdata;
	logic               link_we;
	logic [BLK_W-1:0]   link_waddr;
	logic [LINK_W-1:0]  link_wdata;
	logic [LINK_W-1:0]  link_rdata;

	assign flim = (file_lim_q > FLIM_W'(NUM_FILES)) ? FLIM_W'(NUM_FILES) : file_lim_q;
	assign blim = (blk_lim_q > BLIM_W'(DISK_BLOCKS)) ? BLIM_W'(DISK_BLOCKS) : blk_lim_q;

	always_comb begin
		ffound = 1'b0;
		fidx   = '0;
		for (int i = NUM_FILES - 1; i >= 0; i--) begin
			if (i < flim && !used_q[i]) begin
				ffound = 1'b1;
				fidx   = FILE_W'(i);
			end
		end
	end

	assign hops   = item_q.position[POS_W-1:OFF_W];
	assign off    = item_q.position[OFF_W-1:0];
	assign size_b = {1'b0, item_q.alloc_size} + (SIZE_W+1)'(ALLOC_BIAS);
	assign need   = (item_q.alloc_size > SIZE_W'(BLOCK_BYTES))
		? NEED_W'(size_b >> OFF_W) + NEED_W'(1) : NEED_W'(1);
	assign scan_free = free_q[scan_q[BLK_W-1:0]];

	assign sts.clear_done = (clr_q == {BADDR_W{1'b1}});
	assign sts.func       = item_q.func;
	assign sts.file_found = ffound;
	assign sts.file_ok    = used_q[item_q.file_index];
	assign sts.scan_end   = ({1'b0, scan_q} >= {1'b0, blim});
	assign sts.scan_free  = scan_free;
	assign sts.enough     = (NEED_W'(avail_q) >= need);
	assign sts.first_take = (taken_q == '0);
	assign sts.taken_all  = (taken_q == need);
	assign sts.hops_done  = (hop_q == hops);
	assign sts.rb_free    = free_q[rb_q];
	assign sts.link_end   = (link_rdata == LINK_END);

	assign byte_we    = cmd.clr_step || cmd.byte_wr;
	assign byte_waddr = cmd.clr_step ? clr_q : {rb_q, off};
	assign byte_wdata = cmd.clr_step ? '0 : item_q.write_data;

	assign link_we    = cmd.take || cmd.link_wr;
	assign link_waddr = cmd.take ? scan_q[BLK_W-1:0] : rb_q;
	assign link_wdata = cmd.take ? LINK_END : LINK_W'(scan_q[BLK_W-1:0]);

	lbfs_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DISK_BLOCKS * BLOCK_BYTES)
	) u_byte_ram (
		.clk  (clk),
		.we   (byte_we),
		.waddr(byte_waddr),
		.wdata(byte_wdata),
		.raddr({rb_q, off}),
		.rdata(byte_rdata)
	);

	lbfs_ram #(
		.WIDTH(LINK_W),
		.DEPTH(DISK_BLOCKS)
	) u_link_ram (
		.clk  (clk),
		.we   (link_we),
		.waddr(link_waddr),
		.wdata(link_wdata),
		.raddr(rb_q),
		.rdata(link_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_lim_q  <= BLIM_W'(DISK_BLOCKS);
			file_lim_q <= FLIM_W'(NUM_FILES);
			used_q     <= '0;
			free_q     <= '1;
			hop_q      <= '0;
			scan_q     <= '0;
			avail_q    <= '0;
			taken_q    <= '0;
			clr_q      <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_BLOCKS: blk_lim_q  <= cfg_wdata[BLIM_W-1:0];
					CFG_FILES:  file_lim_q <= cfg_wdata[FLIM_W-1:0];
					default: ;
				endcase
			end
			if (cmd.clr_step) clr_q <= clr_q + BADDR_W'(1);
			if (cmd.latch || cmd.scan_rst) scan_q <= '0;
			else if (cmd.scan_step || cmd.cnt_step) scan_q <= scan_q + SCAN_W'(1);
			if (cmd.latch) begin
				avail_q <= '0;
				taken_q <= '0;
			end else begin
				if (cmd.cnt_step && scan_free) avail_q <= avail_q + SCAN_W'(1);
				if (cmd.take) taken_q <= taken_q + NEED_W'(1);
			end
			if (cmd.take) free_q[scan_q[BLK_W-1:0]] <= 1'b0;
			if (cmd.file_commit) used_q[fidx] <= 1'b1;
			if (cmd.rb_first) hop_q <= '0;
			else if (cmd.rb_follow || cmd.link_wr) hop_q <= hop_q + HOP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) item_q <= in_data;
		if (cmd.file_commit) begin
			first_q[fidx] <= scan_q[BLK_W-1:0];
			len_q[fidx]   <= item_q.alloc_size;
			fnew_q        <= fidx;
		end
		if (cmd.byte_wr && ({1'b0, item_q.position} >= len_q[item_q.file_index])) begin
			len_q[item_q.file_index] <= SIZE_W'(item_q.position) + SIZE_W'(1);
		end
		if (cmd.rb_first) rb_q <= first_q[item_q.file_index];
		else if (cmd.rb_follow) rb_q <= link_rdata[BLK_W-1:0];
		else if (cmd.file_commit || cmd.link_wr) rb_q <= scan_q[BLK_W-1:0];
		if (cmd.res_load) begin
			out_q.status   <= cmd.res_status;
			out_q.new_file <= cmd.res_newf ? fnew_q : '0;
			unique case (cmd.res_rdsel)
				RD_ZERO: out_q.read_data <= '0;
				RD_FF:   out_q.read_data <= '1;
				RD_MEM:  out_q.read_data <= byte_rdata;
				default: out_q.read_data <= '0;
			endcase
		end
	end

	assign out_data = out_q;

endmodule

[design/linked_block_file_store_unit.sv]
// ----------------------------------------------------------------------------
// linked_block_file_store_unit
// File store on linked disk blocks: allocate, read byte, write byte.
//
//   channel   signals                          payload
//   in        in_valid / in_stall / in_data    func, file_index, position,
//                                              alloc_size, write_data
//   out       out_valid / out_stall / out_data status, new_file, read_data
//   cfg       cfg_we / cfg_index / cfg_wdata   blocks_in_use, files_in_use
//
// One command at a time. Allocate counts the free map, then scans it again
// to take blocks. Read and write follow the link chain hop by hop, and
// each chain extension of a write adds a free-map scan. After reset a
// clearing pass writes all 32768 bytes, one a cycle, with in_stall high.
// A result waits in the output register while the next command is taken.
// ----------------------------------------------------------------------------
module linked_block_file_store_unit
	import lbfs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_t                  in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_t                 out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	cmd_t cmd;
	sts_t sts;

	lbfs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	lbfs_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_data  (in_data),
		.out_data (out_data),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule

[design/lbfs_checker.sv]
// ----------------------------------------------------------------------------
// lbfs_checker
// Port-level checks of the file store, bound to the top level.
// ----------------------------------------------------------------------------
`include "linked_block_file_store_unit_defines.svh"

module lbfs_checker
	import lbfs_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input out_t                 out_data
);

	`LBFS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
	`LBFS_ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall)
	`LBFS_ASSERT_SAME(a_new_file_ok, out_valid && out_data.new_file != '0, out_data.status == ST_OK)
	`LBFS_ASSERT_SAME(a_fail_no_data, out_valid && out_data.status != ST_OK, out_data.read_data == '0 || out_data.read_data == '1)

endmodule

bind linked_block_file_store_unit lbfs_checker u_lbfs_checker (.*);

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives allocate, read and write commands into the linked block file store
// and compares every result with a built-in model of the file and block
// tables. Both channels idle and stall in random bursts; the register
// settings change between phases once all results have drained.
// ----------------------------------------------------------------------------
module testbench;
	import lbfs_pkg::*;

	localparam logic [LINK_W-1:0] LINK_FREE_C = 8'hFF;

	class file_store_scoreboard;
		out_t              expected_q[$];
		int                errors;
		int unsigned       blk_limit;
		int unsigned       file_limit;
		bit                used[NUM_FILES];
		int unsigned       first_blk[NUM_FILES];
		int unsigned       length[NUM_FILES];
		logic [LINK_W-1:0] link[DISK_BLOCKS];
		logic [7:0]        disk[DISK_BLOCKS*BLOCK_BYTES];

		function new();
			errors = 0;
			blk_limit = 64;
			file_limit = 16;
			foreach (used[i]) begin
				used[i] = 0;
				first_blk[i] = 0;
				length[i] = 0;
			end
			foreach (link[i]) link[i] = LINK_FREE_C;
			foreach (disk[i]) disk[i] = 8'h00;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			if (idx == CFG_BLOCKS) blk_limit = val;
			else file_limit = val[FLIM_W-1:0];
		endfunction

		function int take_block();
			int lim;
			lim = blk_limit < DISK_BLOCKS ? blk_limit : DISK_BLOCKS;
			for (int i = 0; i < lim; i++) begin
				if (link[i] == LINK_FREE_C) begin
					link[i] = LINK_END;
					return i;
				end
			end
			return -1;
		endfunction

		function out_t create_entry(int unsigned sz);
			out_t r;
			int f, need, acc, avail, lim, cur, nb;
			r = '0;
			f = -1;
			lim = file_limit < NUM_FILES ? file_limit : NUM_FILES;
			for (int i = 0; i < lim; i++)
				if (!used[i] && f < 0) f = i;
			if (f < 0) begin
				r.status = ST_NO_FILE;
				return r;
			end
			need = 1;
			if (sz > BLOCK_BYTES) begin
				acc = -(3 * BLOCK_BYTES) / 4;
				while (acc < int'(sz)) begin
					need++;
					acc += BLOCK_BYTES;
				end
			end
			avail = 0;
			lim = blk_limit < DISK_BLOCKS ? blk_limit : DISK_BLOCKS;
			for (int i = 0; i < lim; i++)
				if (link[i] == LINK_FREE_C) avail++;
			if (avail < need) begin
				r.status = ST_NO_BLOCK;
				return r;
			end
			cur = take_block();
			used[f] = 1;
			first_blk[f] = cur;
			length[f] = sz;
			for (int k = 1; k < need; k++) begin
				nb = take_block();
				link[cur] = LINK_W'(nb);
				cur = nb;
			end
			r.status = ST_OK;
			r.new_file = FILE_W'(f);
			return r;
		endfunction

		function out_t access_byte(bit wr, int unsigned f, int unsigned pos,
				logic [7:0] wd);
			out_t r;
			int unsigned blk, hops, off;
			int nb;
			r = '0;
			r.read_data = wr ? 8'h00 : 8'hFF;
			if (f >= NUM_FILES || !used[f]) begin
				r.status = ST_NOT_USED;
				return r;
			end
			blk = first_blk[f];
			hops = pos / BLOCK_BYTES;
			off = pos % BLOCK_BYTES;
			for (int h = 0; h < hops; h++) begin
				if (link[blk] == LINK_FREE_C) begin
					r.status = ST_PAST_END;
					return r;
				end
				if (link[blk] == LINK_END) begin
					if (!wr) begin
						r.status = ST_PAST_END;
						return r;
					end
					nb = take_block();
					if (nb < 0) begin
						r.status = ST_NO_BLOCK;
						return r;
					end
					link[blk] = LINK_W'(nb);
					blk = nb;
				end else begin
					blk = link[blk];
				end
			end
			r.status = ST_OK;
			if (!wr) begin
				r.read_data = disk[blk * BLOCK_BYTES + off];
				return r;
			end
			if (pos >= length[f]) length[f] = pos + 1;
			disk[blk * BLOCK_BYTES + off] = wd;
			return r;
		endfunction

		function void note_command(in_t c);
			out_t r;
			r = '0;
			case (c.func)
				FN_ALLOC: r = create_entry(c.alloc_size);
				FN_READ:  r = access_byte(0, c.file_index, c.position, 8'h00);
				FN_WRITE: r = access_byte(1, c.file_index, c.position, c.write_data);
				default:  r = '0;
			endcase
			expected_q.push_back(r);
		endfunction

		function void check_result(out_t got);
			out_t e;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result status=%0d new_file=%0d read_data=%0h",
					$time, got.status, got.new_file, got.read_data);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (got.status !== e.status) begin
				$display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
				errors++;
			end
			if (got.new_file !== e.new_file) begin
				$display("%0t: new_file expected %0d actual %0d", $time, e.new_file,
					got.new_file);
				errors++;
			end
			if (got.read_data !== e.read_data) begin
				$display("%0t: read_data expected %0h actual %0h", $time, e.read_data,
					got.read_data);
				errors++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	in_t                  in_data;
	logic                 out_valid;
	logic                 out_stall;
	out_t                 out_data;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	file_store_scoreboard sb;
	bit                   quiet;
	int                   long_hold_req;

	linked_block_file_store_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	always #6 clk = ~clk;

	function automatic in_t make_cmd(logic [FUNC_W-1:0] fn, int unsigned f,
			int unsigned pos, int unsigned sz, int unsigned wd);
		in_t c;
		c.func = fn;
		c.file_index = FILE_W'(f);
		c.position = POS_W'(pos);
		c.alloc_size = SIZE_W'(sz);
		c.write_data = DATA_W'(wd);
		return c;
	endfunction

	task automatic send_cmd(in_t c);
		in_valid <= 1'b1;
		in_data <= c;
		do @(posedge clk); while (in_stall);
		sb.note_command(c);
		@(negedge clk);
	endtask

	task automatic idle_sender();
		int n;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			n = $urandom_range(1, 16);
			in_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, int unsigned val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= CFG_W'(val);
		sb.set_register(idx, CFG_W'(val));
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_limits(int unsigned blocks, int unsigned files);
		drain();
		write_register(CFG_BLOCKS, blocks);
		write_register(CFG_FILES, files);
	endtask

	function automatic in_t random_cmd();
		int unsigned f, pos, sz, pick;
		int          used_list[$];
		for (int i = 0; i < NUM_FILES; i++)
			if (sb.used[i]) used_list.push_back(i);
		f = $urandom_range(0, NUM_FILES - 1);
		if (used_list.size() != 0 && $urandom_range(0, 3) != 0)
			f = used_list[$urandom_range(0, used_list.size() - 1)];
		if ($urandom_range(0, 19) == 0) pos = $urandom_range(0, 32767);
		else pos = $urandom_range(0, 3) * BLOCK_BYTES + $urandom_range(0, BLOCK_BYTES - 1);
		if ($urandom_range(0, 9) == 0) sz = $urandom_range(0, 32768);
		else sz = $urandom_range(0, 2000);
		pick = $urandom_range(0, 99);
		if (pick < 8) return make_cmd(FN_ALLOC, f, pos, sz, $urandom_range(0, 255));
		if (pick < 10) return make_cmd(FN_NONE, f, pos, sz, $urandom_range(0, 255));
		if (pick < 55) return make_cmd(FN_READ, f, pos, sz, $urandom_range(0, 255));
		return make_cmd(FN_WRITE, f, pos, sz, $urandom_range(0, 255));
	endfunction

	initial begin
		int hold;
		hold = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) sb.check_result(out_data);
			@(negedge clk);
			if (long_hold_req > 0) begin
				hold = long_hold_req;
				long_hold_req = 0;
			end
			if (hold == 0 && !quiet && $urandom_range(0, 7) == 0)
				hold = $urandom_range(1, 16);
			if (hold > 0) begin
				out_stall <= 1'b1;
				hold--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		#40ms;
		$display("testbench failed");
		$finish;
	end

	initial begin
		sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		quiet = 0;
		long_hold_req = 0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		write_register(CFG_BLOCKS, 8);
		write_register(CFG_FILES, 4);
		send_cmd(make_cmd(FN_READ, 0, 0, 0, 0));
		send_cmd(make_cmd(FN_WRITE, 15, 32767, 65535, 255));
		send_cmd(make_cmd(FN_NONE, 15, 32767, 65535, 255));
		send_cmd(make_cmd(FN_ALLOC, 0, 0, 0, 0));
		send_cmd(make_cmd(FN_ALLOC, 0, 0, 513, 0));
		send_cmd(make_cmd(FN_ALLOC, 0, 0, 32768, 0));
		send_cmd(make_cmd(FN_WRITE, 0, 0, 0, 255));
		send_cmd(make_cmd(FN_READ, 0, 0, 0, 0));
		send_cmd(make_cmd(FN_READ, 0, 512, 0, 0));
		idle_sender();
		send_cmd(make_cmd(FN_WRITE, 0, 1023, 0, 8'h5A));
		send_cmd(make_cmd(FN_READ, 0, 1023, 0, 0));
		send_cmd(make_cmd(FN_READ, 1, 1535, 0, 0));
		send_cmd(make_cmd(FN_READ, 1, 1536, 0, 0));
		send_cmd(make_cmd(FN_WRITE, 1, 600, 0, 8'hA5));
		send_cmd(make_cmd(FN_READ, 1, 600, 0, 0));
		send_cmd(make_cmd(FN_WRITE, 0, 32767, 0, 8'hAA));
		send_cmd(make_cmd(FN_READ, 0, 32767, 0, 0));
		send_cmd(make_cmd(FN_ALLOC, 0, 0, 1, 0));
		send_cmd(make_cmd(FN_ALLOC, 0, 0, 1, 0));
		send_cmd(make_cmd(FN_ALLOC, 0, 0, 1, 0));
		set_limits(64, 1);
		send_cmd(make_cmd(FN_ALLOC, 0, 0, 10, 0));
		set_limits(1, 16);
		send_cmd(make_cmd(FN_ALLOC, 0, 0, 10, 0));
		set_limits(64, 16);

		for (int n = 0; n < 950; n++) begin
			if (n == 320) set_limits(20, 6);
			if (n == 640) set_limits(64, 16);
			if (n == 200) long_hold_req = 600;
			if (n == 450) begin
				in_valid <= 1'b0;
				while (sb.expected_q.size() != 0) @(negedge clk);
			end
			if (n == 860) quiet = 1;
			send_cmd(random_cmd());
			idle_sender();
		end
		drain();
		repeat (100) @(negedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule

[filelist.f]
+incdir+design
design/lbfs_pkg.sv
design/lbfs_ram.sv
design/lbfs_ctrl.sv
design/lbfs_dpath.sv
design/linked_block_file_store_unit.sv
design/lbfs_checker.sv
tb/testbench.sv
